// ===== hw/rtl/wegs_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// wegs_pkg
// Shared constants, codes and controller/datapath interface types.
// -----------------------------------------------------------------------------
package wegs_pkg;

	// grid geometry (power of two so that row/col wrap by truncation)
	localparam int GRID_SIZE = 256;
	localparam int IDX_W     = $clog2(GRID_SIZE);
	localparam int ADDR_W    = 2 * IDX_W;

	localparam int DISP_W = 32;
	localparam int SPD_W  = 17;
	localparam int SW_W   = SPD_W + 1;

	localparam logic [SPD_W-1:0] SPEED_ONE   = 17'd65536;
	localparam logic [SPD_W-1:0] COURANT_RST = 17'd32768;

	// request and reply codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// stencil operand slots
	localparam logic [2:0] SLOT_C  = 3'd0;
	localparam logic [2:0] SLOT_DN = 3'd1;
	localparam logic [2:0] SLOT_UP = 3'd2;
	localparam logic [2:0] SLOT_RT = 3'd3;
	localparam logic [2:0] SLOT_LF = 3'd4;

	typedef struct packed {
		logic       rd_en;
		logic       rd_from_req;
		logic [2:0] slot;
		logic       acc_clr;
		logic       mul_term;
		logic [2:0] term_k;
		logic       mul_crt;
		logic       cell_inc;
		logic       clr_wr;
		logic       ld_wr;
		logic       swap;
		logic       sat_clr;
		logic       out_ld;
		logic [1:0] out_kind;
	} cmd_t;

	typedef struct packed {
		logic cell_last;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wegs_datapath.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// wegs_datapath
// Grid memories, cell sweep counter, shared multiplier, accumulator, result reg.
// -----------------------------------------------------------------------------
module wegs_datapath import wegs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [IDX_W-1:0]  req_row,
	input  logic [IDX_W-1:0]  req_col,
	input  logic [DISP_W-1:0] req_cur,
	input  logic [DISP_W-1:0] req_prev,
	input  logic [SPD_W-1:0]  req_spd,
	input  logic              req_wall,
	input  logic              cfg_we,
	input  logic [SPD_W-1:0]  cfg_data,
	output logic [1:0]        out_kind,
	output logic [DISP_W-1:0] out_cur,
	output logic [DISP_W-1:0] out_prev,
	output logic              out_sat
);

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_SIZE - 1);
	localparam int ACC_W  = 38;
	localparam int MB_W   = SPD_W + 1;
	localparam int PROD_W = ACC_W + MB_W;
	localparam int V_W    = PROD_W - 16 + 2;
	localparam logic signed [V_W-1:0] VMAX = V_W'(64'sh7FFFFFFF);
	localparam logic signed [V_W-1:0] VMIN = -VMAX - V_W'(1);

	logic [DISP_W-1:0] mem_a  [GRID_SIZE*GRID_SIZE];
	logic [DISP_W-1:0] mem_b  [GRID_SIZE*GRID_SIZE];
	logic [SW_W-1:0]   mem_sw [GRID_SIZE*GRID_SIZE];

	logic [SPD_W-1:0]  courant_q;
	logic              cur_is_b_q;
	logic [IDX_W-1:0]  row_q, col_q;
	logic [DISP_W-1:0] rdq_a, rdq_b;
	logic [SW_W-1:0]   rdq_sw;
	logic              rd_vld_s1;
	logic [2:0]        slot_s1;
	logic [DISP_W-1:0] u_q   [5];
	logic [SPD_W-1:0]  spd_q [5];
	logic              wall_q [1:4];
	logic [DISP_W-1:0] up_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic              term_vld_s1, term_sub_s1, crt_vld_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic              sat_q;

	// read address
	logic [IDX_W-1:0] rp, rm, cp, cm;
	logic [ADDR_W-1:0] step_addr, rd_addr, cell_addr, wr_addr;
	assign rp = (row_q == IDX_MAX) ? '0 : row_q + IDX_W'(1);
	assign rm = (row_q == '0) ? IDX_MAX : row_q - IDX_W'(1);
	assign cp = (col_q == IDX_MAX) ? '0 : col_q + IDX_W'(1);
	assign cm = (col_q == '0) ? IDX_MAX : col_q - IDX_W'(1);
	assign cell_addr = {row_q, col_q};

	always_comb begin
		unique case (cmd.slot)
			SLOT_DN: step_addr = {rp, col_q};
			SLOT_UP: step_addr = {rm, col_q};
			SLOT_RT: step_addr = {row_q, cp};
			SLOT_LF: step_addr = {row_q, cm};
			default: step_addr = cell_addr;
		endcase
	end
	assign rd_addr = cmd.rd_from_req ? {req_row, req_col} : step_addr;
	assign wr_addr = cmd.ld_wr ? {req_row, req_col} : cell_addr;

	// new cell value
	logic signed [V_W-3:0]    scaled;
	logic signed [V_W-1:0]    v;
	logic                     v_hi, v_lo;
	logic [DISP_W-1:0]        res;
	assign scaled = prod_s1[PROD_W-1:16];
	assign v = V_W'(scaled) - V_W'($signed(up_q)) + (V_W'($signed(u_q[SLOT_C])) <<< 1);
	assign v_hi = (v > VMAX);
	assign v_lo = (v < VMIN);
	assign res  = v_hi ? DISP_W'(32'h7FFFFFFF) : v_lo ? DISP_W'(32'h80000000) : v[DISP_W-1:0];

	// write ports
	logic we_a, we_b, we_sw;
	logic [DISP_W-1:0] da, db;
	logic [SW_W-1:0]   dsw;
	assign we_a  = cmd.clr_wr | cmd.ld_wr | (crt_vld_s1 & cur_is_b_q);
	assign we_b  = cmd.clr_wr | cmd.ld_wr | (crt_vld_s1 & ~cur_is_b_q);
	assign we_sw = cmd.clr_wr | cmd.ld_wr;
	always_comb begin
		if (cmd.clr_wr) begin
			da  = '0;
			db  = '0;
			dsw = {1'b0, SPEED_ONE};
		end else if (cmd.ld_wr) begin
			da  = cur_is_b_q ? req_prev : req_cur;
			db  = cur_is_b_q ? req_cur : req_prev;
			dsw = {req_wall, req_spd};
		end else begin
			da  = res;
			db  = res;
			dsw = {req_wall, req_spd};
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) mem_a[wr_addr] <= da;
		if (we_b) mem_b[wr_addr] <= db;
		if (we_sw) mem_sw[wr_addr] <= dsw;
		if (cmd.rd_en) begin
			rdq_a  <= mem_a[rd_addr];
			rdq_b  <= mem_b[rd_addr];
			rdq_sw <= mem_sw[rd_addr];
		end
	end

	logic [DISP_W-1:0] rd_cur, rd_prev;
	assign rd_cur  = cur_is_b_q ? rdq_b : rdq_a;
	assign rd_prev = cur_is_b_q ? rdq_a : rdq_b;

	// operand capture
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			u_q[slot_s1]   <= rd_cur;
			spd_q[slot_s1] <= rdq_sw[SPD_W-1:0];
			if (slot_s1 != SLOT_C) wall_q[slot_s1] <= rdq_sw[SPD_W];
			if (slot_s1 == SLOT_C) up_q <= rd_prev;
		end
	end

	// stencil term operands; a wall neighbour is replaced by the opposite one
	logic [DISP_W-1:0] nb;
	logic [SPD_W-1:0]  spd_n;
	logic              sub;
	always_comb begin
		unique case (cmd.term_k)
			SLOT_DN: begin
				nb = wall_q[SLOT_DN] ? u_q[SLOT_UP] : u_q[SLOT_DN];
				spd_n = spd_q[SLOT_DN];
				sub = 1'b0;
			end
			SLOT_UP: begin
				nb = wall_q[SLOT_UP] ? u_q[SLOT_DN] : u_q[SLOT_UP];
				spd_n = spd_q[SLOT_UP];
				sub = 1'b1;
			end
			SLOT_RT: begin
				nb = wall_q[SLOT_RT] ? u_q[SLOT_LF] : u_q[SLOT_RT];
				spd_n = spd_q[SLOT_RT];
				sub = 1'b0;
			end
			SLOT_LF: begin
				nb = wall_q[SLOT_LF] ? u_q[SLOT_RT] : u_q[SLOT_LF];
				spd_n = spd_q[SLOT_LF];
				sub = 1'b1;
			end
			default: begin
				nb = u_q[SLOT_C];
				spd_n = spd_q[SLOT_C];
				sub = 1'b0;
			end
		endcase
	end

	logic [SPD_W:0]               spd_sum;
	logic [SPD_W-1:0]             face;
	logic signed [DISP_W:0]       u0_e, nb_e, diff;
	logic signed [ACC_W-1:0]      mul_a;
	logic signed [MB_W-1:0]       mul_b;
	logic signed [ACC_W-1:0]      term;
	assign spd_sum = {1'b0, spd_q[SLOT_C]} + {1'b0, spd_n};
	assign face = spd_sum[SPD_W:1];
	assign u0_e = {u_q[SLOT_C][DISP_W-1], u_q[SLOT_C]};
	assign nb_e = {nb[DISP_W-1], nb};
	assign diff = sub ? (u0_e - nb_e) : (nb_e - u0_e);
	assign mul_a = cmd.mul_crt ? acc_q : ACC_W'(diff);
	assign mul_b = cmd.mul_crt ? $signed({1'b0, courant_q}) : $signed({1'b0, face});
	assign term  = prod_s1[16 +: ACC_W];

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q   <= COURANT_RST;
			cur_is_b_q  <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			rd_vld_s1   <= 1'b0;
			slot_s1     <= SLOT_C;
			term_vld_s1 <= 1'b0;
			term_sub_s1 <= 1'b0;
			crt_vld_s1  <= 1'b0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_we) courant_q <= cfg_data;
			if (cmd.swap) cur_is_b_q <= ~cur_is_b_q;
			if (cmd.cell_inc) begin
				col_q <= (col_q == IDX_MAX) ? '0 : col_q + IDX_W'(1);
				if (col_q == IDX_MAX) row_q <= (row_q == IDX_MAX) ? '0 : row_q + IDX_W'(1);
			end
			rd_vld_s1   <= cmd.rd_en & ~cmd.rd_from_req;
			slot_s1     <= cmd.slot;
			term_vld_s1 <= cmd.mul_term;
			term_sub_s1 <= sub;
			crt_vld_s1  <= cmd.mul_crt;
			if (cmd.acc_clr) acc_q <= '0;
			else if (term_vld_s1) acc_q <= term_sub_s1 ? acc_q - term : acc_q + term;
			if (cmd.sat_clr) sat_q <= 1'b0;
			else if (crt_vld_s1 && (v_hi || v_lo)) sat_q <= 1'b1;
		end
	end

	assign stat.cell_last = (row_q == IDX_MAX) && (col_q == IDX_MAX);

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_kind <= cmd.out_kind;
			out_cur  <= (cmd.out_kind == REQ_READ) ? rd_cur : '0;
			out_prev <= (cmd.out_kind == REQ_READ) ? rd_prev : '0;
			out_sat  <= (cmd.out_kind == REQ_STEP) ? sat_q : 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wegs_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// wegs_ctrl
// Request sequencer: clear sweep, load/read handling, per-cell step schedule.
// -----------------------------------------------------------------------------
module wegs_ctrl import wegs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] req_type,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_STEP, ST_DONE} state_t;

	localparam logic [3:0] PH_RD_LAST  = 4'd4;
	localparam logic [3:0] PH_MUL_FST  = 4'd6;
	localparam logic [3:0] PH_MUL_LAST = 4'd9;
	localparam logic [3:0] PH_CRT      = 4'd11;
	localparam logic [3:0] PH_WR       = 4'd12;

	state_t     state_q;
	logic [3:0] phase_q;
	logic       out_valid_q;
	logic       acc;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc      = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr   = 1'b1;
				cmd.cell_inc = 1'b1;
			end
			ST_IDLE: begin
				if (acc) begin
					priority case (req_type)
						REQ_LOAD: begin
							cmd.ld_wr    = 1'b1;
							cmd.out_ld   = 1'b1;
							cmd.out_kind = REQ_LOAD;
						end
						REQ_STEP: cmd.sat_clr = 1'b1;
						REQ_READ: begin
							cmd.rd_en       = 1'b1;
							cmd.rd_from_req = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.out_ld   = 1'b1;
				cmd.out_kind = REQ_READ;
			end
			ST_STEP: begin
				if (phase_q <= PH_RD_LAST) begin
					cmd.rd_en   = 1'b1;
					cmd.slot    = phase_q[2:0];
					cmd.acc_clr = (phase_q == '0);
				end
				if (phase_q >= PH_MUL_FST && phase_q <= PH_MUL_LAST) begin
					cmd.mul_term = 1'b1;
					cmd.term_k   = 3'(phase_q - PH_MUL_FST + 4'd1);
				end
				cmd.mul_crt  = (phase_q == PH_CRT);
				cmd.cell_inc = (phase_q == PH_WR);
				cmd.swap     = (phase_q == PH_WR) && stat.cell_last;
			end
			ST_DONE: begin
				cmd.out_ld   = 1'b1;
				cmd.out_kind = REQ_STEP;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: if (stat.cell_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (acc && req_type == REQ_STEP) begin
						state_q <= ST_STEP;
						phase_q <= '0;
					end else if (acc && req_type == REQ_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_STEP: begin
					if (phase_q == PH_WR) begin
						phase_q <= '0;
						if (stat.cell_last) state_q <= ST_DONE;
					end else begin
						phase_q <= phase_q + 4'd1;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// the shared multiplier serves one user per cycle
	a_mul_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_term && cmd.mul_crt))
		else $error("multiplier conflict");

	// grids swap only at the end of a sweep, followed by the step reply
	a_swap_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap |=> (state_q == ST_DONE))
		else $error("swap without step completion");

endmodule
`default_nettype wire

// ===== hw/rtl/wave_equation_grid_step.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// wave_equation_grid_step
// 2D variable-speed wave-equation engine on a periodic 256x256 grid.
// -----------------------------------------------------------------------------
// After reset the block sweeps all 65536 cells once to zero the displacement
// grids, set speeds to 1.0 and clear walls; s_tready stays low during that
// pass. Load: one transaction, reply next cycle. Read: the cell is read into
// the memory read register on accept, then loaded into the reply register.
// Step: each cell follows a schedule of five single-port reads (center and
// four neighbours) followed by five passes through one shared multiplier
// (four face products, then the Courant scale). Results wait in an output
// register; a new request is accepted in the same cycle the previous reply
// is taken. Request code 3 is consumed silently. courant_sq may only be
// written while the block is idle.
// -----------------------------------------------------------------------------
module wave_equation_grid_step import wegs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row[7:0], col[15:8], load_current[47:16], load_previous[79:48],
	// load_speed[96:80], load_wall[97], zero fill [103:98]
	input  logic [103:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cell_current[31:0], cell_previous[63:32], saturated[64], zero fill [71:65]
	output logic [71:0]  m_tdata,
	// reply_kind[1:0]
	output logic [1:0]   m_tuser,
	input  logic         courant_sq_we,
	input  logic [16:0]  courant_sq
);

	cmd_t  cmd;
	stat_t stat;

	logic [DISP_W-1:0] out_cur, out_prev;
	logic              out_sat;

	// controller: request sequencing and the per-cell step schedule
	wegs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: memories, stencil arithmetic, reply register
	wegs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_row  (s_tdata[IDX_W-1:0]),
		.req_col  (s_tdata[8 +: IDX_W]),
		.req_cur  (s_tdata[47:16]),
		.req_prev (s_tdata[79:48]),
		.req_spd  (s_tdata[96:80]),
		.req_wall (s_tdata[97]),
		.cfg_we   (courant_sq_we),
		.cfg_data (courant_sq),
		.out_kind (m_tuser),
		.out_cur  (out_cur),
		.out_prev (out_prev),
		.out_sat  (out_sat)
	);

	assign m_tdata = {7'd0, out_sat, out_prev, out_cur};

endmodule
`default_nettype wire
